// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the LZW decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge out of reset.
`define GLZW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication: antecedent at one edge, consequent at the same edge.
`define GLZW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication: antecedent at one edge, consequent at the next edge.
`define GLZW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/glzw_pkg.sv =====
// ----------------------------------------------------------------------------
// glzw_pkg
// Types, constants and helpers shared by the LZW decoder modules.
// ----------------------------------------------------------------------------
package glzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int SYMBOL_BITS   = 8;
    localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
    localparam int CNT_W         = MAX_CODE_BITS + 1;
    localparam int BUF_W         = MAX_CODE_BITS + SYMBOL_BITS;
    localparam int BCNT_W        = 5;
    localparam int DICT_W        = MAX_CODE_BITS + SYMBOL_BITS;

    // reset values follow a minimum code size of eight
    localparam logic [3:0]       MIN_SIZE_RST = 4'd8;
    localparam logic [3:0]       CW_RST       = 4'd9;
    localparam logic [CNT_W-1:0] NF_RST       = CNT_W'(258);

    localparam logic CFG_MIN_SIZE    = 1'b0;
    localparam logic CFG_PIXEL_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PULL  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_PIXEL = 2'd0,
        ST_NEED  = 2'd1,
        ST_DONE  = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FIN_RUN   = 2'd0,
        FIN_DONE  = 2'd1,
        FIN_ERROR = 2'd2,
        FIN_RSVD  = 2'd3
    } t_fin;

    typedef struct packed {
        t_op                    op;
        logic [SYMBOL_BITS-1:0] data_byte;
    } t_item;

    // minimum code size clamped to [2, SYMBOL_BITS]
    function automatic logic [3:0] eff_min_size(input logic [3:0] s);
        logic [3:0] r;
        r = s;
        if (r < 4'd2) r = 4'd2;
        if (r > 4'(SYMBOL_BITS)) r = 4'(SYMBOL_BITS);
        return r;
    endfunction

endpackage

// ===== rtl/core/glzw_front.sv =====
// ----------------------------------------------------------------------------
// glzw_front
// Input side: takes stream transfers, drops empty ops, queues the rest.
// ----------------------------------------------------------------------------
module glzw_front
    import glzw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_item_valid,
    input  logic  i_item_ready,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign push         = i_valid && o_ready && (i_item.op != OP_NONE);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];
    assign pop          = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

endmodule

// ===== rtl/core/glzw_engine.sv =====
// ----------------------------------------------------------------------------
// glzw_engine
// Back end: bit unpacking, dictionary, chain walk, string stack, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glzw_engine
    import glzw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [3:0]             i_min_size,
    input  logic [31:0]            i_pixel_limit,
    input  logic                   i_item_valid,
    output logic                   o_item_ready,
    input  t_item                  i_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SYMBOL_BITS-1:0] o_pixel,
    output t_status                o_status,
    output logic [31:0]            o_count
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_WALK   = 6'b000100,
        S_TAIL   = 6'b001000,
        S_KW     = 6'b010000,
        S_POP    = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [BUF_W-1:0]         r_buf, n_buf;
    logic [BCNT_W-1:0]        r_bcnt, n_bcnt;
    logic [3:0]               r_cw, n_cw;
    logic [CNT_W-1:0]         r_nf, n_nf;
    logic [MAX_CODE_BITS-1:0] r_prev, n_prev;
    logic                     r_prev_valid, n_prev_valid;
    logic [31:0]              r_pix_cnt, n_pix_cnt;
    t_fin                     r_fin, n_fin;
    logic [CNT_W-1:0]         r_depth, n_depth;
    logic [MAX_CODE_BITS-1:0] r_code, n_code;
    logic [MAX_CODE_BITS-1:0] r_c, n_c;
    logic                     r_kw, n_kw;
    logic [SYMBOL_BITS-1:0]   r_first, n_first;
    logic                     r_out_valid, n_out_valid;
    logic [SYMBOL_BITS-1:0]   r_out_pix, n_out_pix;
    t_status                  r_out_status, n_out_status;
    logic [31:0]              r_out_count, n_out_count;

    logic [DICT_W-1:0]        r_dict [TABLE_SIZE];
    logic [SYMBOL_BITS-1:0]   r_stk [TABLE_SIZE];
    logic [DICT_W-1:0]        r_dict_rd;
    logic [SYMBOL_BITS-1:0]   r_stk_rd;

    logic                     dict_we, dict_re, stk_we, stk_re;
    logic [MAX_CODE_BITS-1:0] dict_wa, dict_ra, stk_wa, stk_ra;
    logic [DICT_W-1:0]        dict_wd;
    logic [SYMBOL_BITS-1:0]   stk_wd;
    logic                     add_en;
    logic [SYMBOL_BITS-1:0]   add_sym;

    logic [3:0]               eff;
    logic [CNT_W-1:0]         clr;
    logic [BUF_W-1:0]         cmask;
    logic [MAX_CODE_BITS-1:0] code;
    logic [MAX_CODE_BITS-1:0] walk_pre;
    logic [CNT_W-1:0]         nf_inc;

    assign eff      = eff_min_size(i_min_size);
    assign clr      = CNT_W'(1) << eff;
    assign cmask    = (BUF_W'(1) << r_cw) - BUF_W'(1);
    assign code     = MAX_CODE_BITS'(r_buf & cmask);
    assign walk_pre = r_dict_rd[DICT_W-1:SYMBOL_BITS];
    assign nf_inc   = r_nf + CNT_W'(1);

    // a pull needs the result register free, since it always answers
    assign o_item_ready = (r_state == S_IDLE) && !(i_item.op == OP_PULL && r_out_valid);

    always_comb begin
        n_state      = r_state;
        n_buf        = r_buf;
        n_bcnt       = r_bcnt;
        n_cw         = r_cw;
        n_nf         = r_nf;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_pix_cnt    = r_pix_cnt;
        n_fin        = r_fin;
        n_depth      = r_depth;
        n_code       = r_code;
        n_c          = r_c;
        n_kw         = r_kw;
        n_first      = r_first;
        n_out_valid  = r_out_valid;
        n_out_pix    = r_out_pix;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        dict_we = 1'b0;
        dict_wa = r_nf[MAX_CODE_BITS-1:0];
        dict_wd = {r_prev, add_sym};
        dict_re = 1'b0;
        dict_ra = code;
        stk_we  = 1'b0;
        stk_wa  = r_depth[MAX_CODE_BITS-1:0];
        stk_wd  = r_c[SYMBOL_BITS-1:0];
        stk_re  = 1'b0;
        stk_ra  = MAX_CODE_BITS'(r_depth - CNT_W'(1));
        add_en  = 1'b0;
        add_sym = r_c[SYMBOL_BITS-1:0];

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid && o_item_ready) begin
                    case (i_item.op)
                        OP_LOAD: begin
                            if (r_fin == FIN_RUN && r_bcnt <= BCNT_W'(MAX_CODE_BITS)) begin
                                n_buf  = r_buf | (BUF_W'(i_item.data_byte) << r_bcnt);
                                n_bcnt = r_bcnt + BCNT_W'(SYMBOL_BITS);
                            end
                        end
                        OP_START: begin
                            n_cw         = eff + 4'd1;
                            n_nf         = clr + CNT_W'(2);
                            n_prev_valid = 1'b0;
                            n_depth      = '0;
                            n_buf        = '0;
                            n_bcnt       = '0;
                            n_prev       = '0;
                            n_pix_cnt    = '0;
                            n_fin        = FIN_RUN;
                        end
                        OP_PULL: n_state = S_DECODE;
                        default: ;
                    endcase
                end
            end
            S_DECODE: begin
                n_out_pix   = '0;
                n_out_count = r_pix_cnt;
                if (r_fin == FIN_DONE) begin
                    n_out_valid = 1'b1; n_out_status = ST_DONE; n_state = S_IDLE;
                end else if (r_fin == FIN_ERROR) begin
                    n_out_valid = 1'b1; n_out_status = ST_ERROR; n_state = S_IDLE;
                end else if (r_pix_cnt >= i_pixel_limit) begin
                    n_fin = FIN_DONE;
                    n_out_valid = 1'b1; n_out_status = ST_DONE; n_state = S_IDLE;
                end else if (r_depth != '0) begin
                    stk_re    = 1'b1;
                    n_depth   = r_depth - CNT_W'(1);
                    n_pix_cnt = r_pix_cnt + 32'd1;
                    n_state   = S_POP;
                end else if (r_bcnt < BCNT_W'(r_cw)) begin
                    n_out_valid = 1'b1; n_out_status = ST_NEED; n_state = S_IDLE;
                end else begin
                    n_buf  = r_buf >> r_cw;
                    n_bcnt = r_bcnt - BCNT_W'(r_cw);
                    n_code = code;
                    if (CNT_W'(code) == clr) begin
                        // clear: restart table, keep reading codes
                        n_cw         = eff + 4'd1;
                        n_nf         = clr + CNT_W'(2);
                        n_prev_valid = 1'b0;
                    end else if (CNT_W'(code) == clr + CNT_W'(1)) begin
                        n_fin = FIN_DONE;
                        n_out_valid = 1'b1; n_out_status = ST_DONE; n_state = S_IDLE;
                    end else if (CNT_W'(code) < r_nf) begin
                        n_depth = '0;
                        n_kw    = 1'b0;
                        if (CNT_W'(code) < clr) begin
                            n_c     = code;
                            n_state = S_TAIL;
                        end else begin
                            dict_re = 1'b1;
                            dict_ra = code;
                            n_state = S_WALK;
                        end
                    end else if (CNT_W'(code) == r_nf && r_prev_valid) begin
                        // repeated string: slot 0 is kept for its first symbol
                        n_depth = CNT_W'(1);
                        n_kw    = 1'b1;
                        if (CNT_W'(r_prev) < clr) begin
                            n_c     = r_prev;
                            n_state = S_TAIL;
                        end else begin
                            dict_re = 1'b1;
                            dict_ra = r_prev;
                            n_state = S_WALK;
                        end
                    end else begin
                        n_fin = FIN_ERROR;
                        n_out_valid = 1'b1; n_out_status = ST_ERROR; n_state = S_IDLE;
                    end
                end
            end
            S_WALK: begin
                stk_we  = 1'b1;
                stk_wd  = r_dict_rd[SYMBOL_BITS-1:0];
                n_depth = r_depth + CNT_W'(1);
                if (CNT_W'(walk_pre) >= clr) begin
                    dict_re = 1'b1;
                    dict_ra = walk_pre;
                end else begin
                    n_c     = walk_pre;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                stk_we  = 1'b1;
                n_depth = r_depth + CNT_W'(1);
                if (r_kw) begin
                    n_first = r_c[SYMBOL_BITS-1:0];
                    n_state = S_KW;
                end else begin
                    add_en       = r_prev_valid;
                    n_prev       = r_code;
                    n_prev_valid = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_KW: begin
                stk_we       = 1'b1;
                stk_wa       = '0;
                stk_wd       = r_first;
                add_en       = 1'b1;
                add_sym      = r_first;
                n_prev       = r_code;
                n_prev_valid = 1'b1;
                n_state      = S_DECODE;
            end
            S_POP: begin
                n_out_valid  = 1'b1;
                n_out_pix    = r_stk_rd;
                n_out_status = ST_PIXEL;
                n_out_count  = r_pix_cnt;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // new table entry; width grows when the next code no longer fits
        if (add_en && !r_nf[CNT_W-1]) begin
            dict_we = 1'b1;
            n_nf    = nf_inc;
            if (nf_inc >= (CNT_W'(1) << r_cw) && r_cw < 4'(MAX_CODE_BITS)) n_cw = r_cw + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_buf        <= '0;
            r_bcnt       <= '0;
            r_cw         <= CW_RST;
            r_nf         <= NF_RST;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_pix_cnt    <= '0;
            r_fin        <= FIN_RUN;
            r_depth      <= '0;
            r_kw         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_buf        <= n_buf;
            r_bcnt       <= n_bcnt;
            r_cw         <= n_cw;
            r_nf         <= n_nf;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_pix_cnt    <= n_pix_cnt;
            r_fin        <= n_fin;
            r_depth      <= n_depth;
            r_kw         <= n_kw;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code       <= n_code;
        r_c          <= n_c;
        r_first      <= n_first;
        r_out_pix    <= n_out_pix;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (dict_we) r_dict[dict_wa] <= dict_wd;
        if (dict_re) r_dict_rd <= r_dict[dict_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk[stk_wa] <= stk_wd;
        if (stk_re) r_stk_rd <= r_stk[stk_ra];
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel     = r_out_pix;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

    `GLZW_ASSERT(a_cw_range, r_cw >= 4'd3 && r_cw <= 4'(MAX_CODE_BITS), "code width out of range")
    `GLZW_ASSERT(a_nf_range, r_nf <= CNT_W'(TABLE_SIZE), "next free code beyond table")
    `GLZW_ASSERT(a_bcnt_range, r_bcnt <= BCNT_W'(BUF_W), "bit count beyond buffer")
    `GLZW_ASSERT_IMP(a_pix_count, r_out_valid && r_out_status == ST_PIXEL, r_out_count != 32'd0,
        "pixel given with zero count")
    `GLZW_ASSERT_NXT(a_pop_emit, r_state == S_POP, r_out_valid && r_out_status == ST_PIXEL,
        "stack pop did not produce a pixel")

endmodule

// ===== rtl/core/gif_lzw_decoder.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// GIF LZW decoder: loads compressed bytes, answers pixel pulls one at a time.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Payload
// s         in   i_s_tvalid/o_s_tready tuser op, tdata data_byte
// m         out  o_m_tvalid/i_m_tready tuser status, tdata pixel_index, pixels_out
// cfg       in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// Load and start are served from the queue head in S_IDLE; a stack pop pull
// passes S_DECODE and S_POP, one reading a code adds S_DECODE per code, S_WALK
// per chain link (dictionary read port), S_TAIL, and S_KW for a repeated string.
// Synchronous active-low reset; dictionary and stack need no clearing pass.
// A two-entry input queue and the result register let each side stall alone.
// ----------------------------------------------------------------------------
module gif_lzw_decoder
    import glzw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [7:0] pixel_index, [39:8] pixels_out
    output logic [1:0]  o_m_tuser,   // [1:0] status
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [3:0]             r_min_size;
    logic [31:0]            r_limit;
    t_item                  in_item, q_item;
    logic                   q_valid, q_ready;
    logic [SYMBOL_BITS-1:0] pix;
    t_status                status;
    logic [31:0]            count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_size <= MIN_SIZE_RST;
            r_limit    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_SIZE:    r_min_size <= i_cfg_data[3:0];
                CFG_PIXEL_LIMIT: r_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.op        = t_op'(i_s_tuser);
    assign in_item.data_byte = i_s_tdata;

    glzw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_item       (in_item),
        .o_item_valid (q_valid),
        .i_item_ready (q_ready),
        .o_item       (q_item)
    );

    glzw_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_size    (r_min_size),
        .i_pixel_limit (r_limit),
        .i_item_valid  (q_valid),
        .o_item_ready  (q_ready),
        .i_item        (q_item),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_pixel       (pix),
        .o_status      (status),
        .o_count       (count)
    );

    assign o_m_tdata = {count, pix};
    assign o_m_tuser = status;

endmodule
